### hdl/skit_pkg.sv
// shared types, request codes and helpers for the serial keyed instance table
// depends on nothing; used by skit_pick and serial_keyed_lru_instance_table_top
`default_nettype none

package skit_pkg;

  // request codes
  localparam logic [1:0] REQ_ACCESS = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // input word
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] raw_serial;
    logic [31:0] now_stamp;
    logic        slot_sel;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        slot;
    logic        hit;
    logic        evicted;
    logic        entry_present;
    logic [31:0] entry_serial;
    logic [7:0]  entry_tag;
    logic [31:0] entry_stamp;
  } out_word_t;

  // lookup status handed from the slot picker to the table control
  typedef struct packed {
    logic hit;
    logic full;
  } pick_flags_t;

  // reverse the byte order of a serial word
  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

### hdl/serial_keyed_lru_instance_table_top.sv
// top level of the serial keyed instance table: input register, slot store,
// result register; depends on skit_pkg and skit_pick
//
// Usage:
//   A request word is taken on in_data at a rising edge where start is high
//   and busy is low. busy is held low: a word can be taken every cycle.
//   Request codes: access by serial, delete slot, read slot; the fourth code
//   changes nothing and gives an all-zero result.
//   Each request gives exactly one result word on out_data, marked by
//   out_valid for a single cycle. A word taken is held in the input register,
//   looked up and applied to the table from there, and its result is captured
//   in the result register and strobed from it; one word per cycle is
//   sustained. The lookup is a parallel compare of all slots, so
//   the table update of one word is seen by the word that follows it.
//   The receiver cannot stall; results must be taken when strobed.
//   Reset (rst_n low, synchronous) clears all slot valid marks, the tag
//   counter and both pipeline valid flags; slot contents are not cleared.
`default_nettype none

module serial_keyed_lru_instance_table_top #(
  parameter int TABLE_SLOTS = 2,
  parameter int TAG_BITS    = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output      logic                busy,
  input  wire skit_pkg::in_word_t  in_data,
  output      logic                out_valid,
  output      skit_pkg::out_word_t out_data
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  // input stage
  logic               in_v_r;
  skit_pkg::in_word_t in_r;

  // slot store
  logic [TABLE_SLOTS-1:0]               valid_r, valid_nxt;
  logic [TABLE_SLOTS-1:0][31:0]         serial_r;
  logic [TABLE_SLOTS-1:0][31:0]         stamp_r;
  logic [TABLE_SLOTS-1:0][TAG_BITS-1:0] tag_r;
  logic [TAG_BITS-1:0]                  tag_cnt_r, tag_cnt_nxt;

  // result stage
  logic                out_valid_r;
  skit_pkg::out_word_t out_r, out_nxt;

  // lookup
  logic [31:0]           key;
  logic [IDX_W-1:0]      pick;
  skit_pkg::pick_flags_t flags;
  logic                  sel_ok;
  logic [IDX_W-1:0]      sel_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic                  wr_en;
  logic                  new_en;

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
  end

  assign key = skit_pkg::swap_bytes(in_r.raw_serial);

  skit_pick #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .IDX_W       (IDX_W)
  ) u_pick (
    .valid  (valid_r),
    .serial (serial_r),
    .stamp  (stamp_r),
    .key    (key),
    .pick   (pick),
    .flags  (flags)
  );

  // slot selector decode
  assign sel_ok  = 32'(in_r.slot_sel) < TABLE_SLOTS;
  assign sel_idx = sel_ok ? IDX_W'(in_r.slot_sel) : '0;
  assign rd_idx  = (in_r.req_type == skit_pkg::REQ_ACCESS) ? pick : sel_idx;

  assign wr_en  = in_v_r && (in_r.req_type == skit_pkg::REQ_ACCESS);
  assign new_en = wr_en && !flags.hit;

  // request decode and result build
  always_comb begin
    valid_nxt   = valid_r;
    tag_cnt_nxt = tag_cnt_r;
    out_nxt     = '0;
    unique case (in_r.req_type)
      skit_pkg::REQ_ACCESS: begin
        if (in_v_r) begin
          valid_nxt[pick] = 1'b1;
        end
        if (new_en) begin
          tag_cnt_nxt = tag_cnt_r + TAG_BITS'(1);
        end
        out_nxt.slot          = pick[0];
        out_nxt.hit           = flags.hit;
        out_nxt.evicted       = !flags.hit && flags.full;
        out_nxt.entry_present = 1'b1;
        out_nxt.entry_serial  = key;
        out_nxt.entry_tag     = flags.hit ? 8'(tag_r[rd_idx]) : 8'(tag_cnt_r);
        out_nxt.entry_stamp   = in_r.now_stamp;
      end
      skit_pkg::REQ_DELETE: begin
        if (in_v_r && sel_ok) begin
          valid_nxt[sel_idx] = 1'b0;
        end
        out_nxt.slot = in_r.slot_sel;
      end
      skit_pkg::REQ_READ: begin
        out_nxt.slot = in_r.slot_sel;
        if (sel_ok && valid_r[sel_idx]) begin
          out_nxt.entry_present = 1'b1;
          out_nxt.entry_serial  = serial_r[rd_idx];
          out_nxt.entry_tag     = 8'(tag_r[rd_idx]);
          out_nxt.entry_stamp   = stamp_r[rd_idx];
        end
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      tag_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      tag_cnt_r   <= tag_cnt_nxt;
      out_valid_r <= in_v_r;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_r[pick] <= in_r.now_stamp;
    end
    if (new_en) begin
      serial_r[pick] <= key;
      tag_r[pick]    <= tag_cnt_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_v_r) begin
      out_r <= out_nxt;
    end
  end

  // checks
  a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |=> out_valid_r)
    else $error("request registered without a result one cycle later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |=> !out_valid_r)
    else $error("result strobed with no request behind it");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.hit |-> !out_r.evicted && out_r.entry_present)
    else $error("hit reported together with eviction or absent entry");

  a_tag_only_new: assert property (@(posedge clk) disable iff (!rst_n)
    !new_en |=> $stable(tag_cnt_r))
    else $error("tag counter moved without a new entry");

  a_del_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && (in_r.req_type == skit_pkg::REQ_DELETE) && sel_ok
    |=> !valid_r[$past(sel_idx)])
    else $error("deleted slot still marked valid");

  a_access_sets: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(pick)])
    else $error("accessed slot not marked valid");

endmodule

`default_nettype wire

### hdl/skit_pick.sv
// slot picker: parallel serial match, lowest free slot and oldest stamp search
// depends on skit_pkg
`default_nettype none

module skit_pick #(
  parameter int TABLE_SLOTS = 2,
  parameter int IDX_W       = 1
) (
  input  wire logic [TABLE_SLOTS-1:0]       valid,
  input  wire logic [TABLE_SLOTS-1:0][31:0] serial,
  input  wire logic [TABLE_SLOTS-1:0][31:0] stamp,
  input  wire logic [31:0]                  key,
  output      logic [IDX_W-1:0]             pick,
  output      skit_pkg::pick_flags_t        flags
);

  logic [TABLE_SLOTS-1:0] match;
  logic [TABLE_SLOTS-1:0] is_min;
  logic [TABLE_SLOTS-1:0] cand;

  // key compare against every slot
  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      match[i] = valid[i] && (serial[i] == key);
    end
  end

  // oldest slot: strictly older than all lower slots, no newer than higher ones
  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      is_min[i] = 1'b1;
      for (int j = 0; j < TABLE_SLOTS; j++) begin
        if (j < i && !(stamp[i] < stamp[j])) begin
          is_min[i] = 1'b0;
        end
        if (j > i && !(stamp[i] <= stamp[j])) begin
          is_min[i] = 1'b0;
        end
      end
    end
  end

  assign flags.hit  = |match;
  assign flags.full = &valid;

  // candidate set: match, else free slots, else oldest
  always_comb begin
    if (flags.hit) begin
      cand = match;
    end else if (!flags.full) begin
      cand = ~valid;
    end else begin
      cand = is_min;
    end
  end

  // lowest set candidate wins
  always_comb begin
    pick = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

### test/instance_table_checker.sv
// result checker for the serial keyed instance table: predicts each result word
// from the accepted request words and compares it with the block's output
// depends on skit_pkg
`timescale 1ns / 100ps

module instance_table_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire skit_pkg::in_word_t  in_data,
  input  wire logic                out_valid,
  input  wire skit_pkg::out_word_t out_data,
  output int                       fail_count,
  output int                       pending
);

  localparam int SLOTS = 2;

  // predicted table contents
  logic        held     [SLOTS];
  logic [31:0] key_of   [SLOTS];
  logic [31:0] stamp_of [SLOTS];
  logic [7:0]  tag_of   [SLOTS];
  logic [7:0]  next_tag;

  skit_pkg::out_word_t owed_results[$];
  int                  errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // apply one request to the predicted table and return the word it should give
  function automatic skit_pkg::out_word_t apply_request(input skit_pkg::in_word_t w);
    skit_pkg::out_word_t r;
    logic [31:0]         key;
    logic [31:0]         oldest;
    int                  pick;
    logic                found;
    logic                free_seen;
    r = '0;
    case (w.req_type)
      skit_pkg::REQ_ACCESS: begin
        key = {w.raw_serial[7:0], w.raw_serial[15:8],
               w.raw_serial[23:16], w.raw_serial[31:24]};
        found     = 1'b0;
        free_seen = 1'b0;
        pick      = 0;
        for (int i = 0; i < SLOTS; i++)
          if (!found && held[i] && key_of[i] == key) begin
            pick  = i;
            found = 1'b1;
          end
        if (!found) begin
          // lowest free slot first
          for (int i = 0; i < SLOTS; i++)
            if (!free_seen && !held[i]) begin
              pick      = i;
              free_seen = 1'b1;
            end
          // table full: smallest stamp, ties to the lower slot
          if (!free_seen) begin
            oldest = 32'hFFFF_FFFF;
            pick   = 0;
            for (int i = 0; i < SLOTS; i++)
              if (stamp_of[i] < oldest) begin
                oldest = stamp_of[i];
                pick   = i;
              end
            r.evicted = 1'b1;
          end
          held[pick]   = 1'b1;
          key_of[pick] = key;
          tag_of[pick] = next_tag;
          next_tag     = next_tag + 8'd1;
        end
        stamp_of[pick]  = w.now_stamp;
        r.slot          = pick[0];
        r.hit           = found;
        r.entry_present = 1'b1;
        r.entry_serial  = key_of[pick];
        r.entry_tag     = tag_of[pick];
        r.entry_stamp   = stamp_of[pick];
      end
      skit_pkg::REQ_DELETE: begin
        held[w.slot_sel] = 1'b0;
        r.slot           = w.slot_sel;
      end
      skit_pkg::REQ_READ: begin
        r.slot = w.slot_sel;
        if (held[w.slot_sel]) begin
          r.entry_present = 1'b1;
          r.entry_serial  = key_of[w.slot_sel];
          r.entry_tag     = tag_of[w.slot_sel];
          r.entry_stamp   = stamp_of[w.slot_sel];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // compare result words first, then log the request word taken at this edge
  always @(posedge clk) begin : watch
    skit_pkg::out_word_t want;
    logic                bad;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        held[i]     = 1'b0;
        key_of[i]   = '0;
        stamp_of[i] = '0;
        tag_of[i]   = '0;
      end
      next_tag = '0;
      owed_results.delete();
    end else begin
      if (out_valid) begin
        if (owed_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word %h at %0t", out_data, $realtime);
        end else begin
          want = owed_results.pop_front();
          bad  = (out_data.slot          !== want.slot)          ||
                 (out_data.hit           !== want.hit)           ||
                 (out_data.evicted       !== want.evicted)       ||
                 (out_data.entry_present !== want.entry_present) ||
                 (out_data.entry_serial  !== want.entry_serial)  ||
                 (out_data.entry_tag     !== want.entry_tag)     ||
                 (out_data.entry_stamp   !== want.entry_stamp);
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: slot %b/%b hit %b/%b evicted %b/%b present %b/%b",
                       $realtime, want.slot, out_data.slot, want.hit, out_data.hit,
                       want.evicted, out_data.evicted,
                       want.entry_present, out_data.entry_present);
              $display("  serial %h/%h tag %h/%h stamp %h/%h (expected/actual)",
                       want.entry_serial, out_data.entry_serial,
                       want.entry_tag, out_data.entry_tag,
                       want.entry_stamp, out_data.entry_stamp);
            end
          end
        end
      end
      if (start && !busy)
        owed_results.push_back(apply_request(in_data));
    end
    fail_count = errors;
    pending    = owed_results.size();
  end

endmodule

### test/tb_top.sv
// testbench top for the serial keyed instance table: clock, reset, request
// stimulus and verdict; depends on skit_pkg, the table top and its checker
`timescale 1ns / 100ps

module tb_top;

  localparam int RANDOM_WORDS = 1000;
  localparam int CYCLE_LIMIT  = 100000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  skit_pkg::in_word_t  in_data;
  logic                out_valid;
  skit_pkg::out_word_t out_data;
  int                  mismatches;
  int                  pending_words;
  int                  cycle_count = 0;

  logic [31:0] serial_pool [4];
  logic [31:0] clock_now;

  serial_keyed_lru_instance_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  instance_table_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (mismatches),
    .pending    (pending_words)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // present one request word and hold it until taken
  task automatic issue(input logic [1:0] req, input logic [31:0] raw,
                       input logic [31:0] now, input logic sel);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= '{req_type: req, raw_serial: raw, now_stamp: now, slot_sel: sel};
    do @(posedge clk); while (busy);
  endtask

  // idle step: start low and junk on the data bus
  task automatic idle_cycle();
    @(negedge clk);
    start   <= 1'b0;
    in_data <= '{req_type: 2'($urandom), raw_serial: $urandom,
                 now_stamp: $urandom, slot_sel: 1'($urandom)};
  endtask

  // hold off until every outstanding result word has come back
  task automatic drain();
    do idle_cycle(); while (pending_words != 0);
  endtask

  initial begin : stimulus
    logic [1:0]  req;
    logic [31:0] raw;
    int          r;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: fill, hit, ties, all-max stamps, free slots, unknown code
    issue(skit_pkg::REQ_READ,   32'h0,          32'h0,          1'b0);
    issue(skit_pkg::REQ_ACCESS, 32'h1122_3344,  32'd5,          1'b0);
    issue(skit_pkg::REQ_ACCESS, 32'h1122_3344,  32'd7,          1'b1);
    issue(skit_pkg::REQ_ACCESS, 32'hFFFF_FFFF,  32'd7,          1'b0);
    issue(skit_pkg::REQ_ACCESS, 32'h0000_0000,  32'd0,          1'b0);
    issue(skit_pkg::REQ_ACCESS, 32'h8000_0001,  32'hFFFF_FFFF,  1'b1);
    issue(skit_pkg::REQ_ACCESS, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0);
    issue(skit_pkg::REQ_ACCESS, 32'h00FF_00FF,  32'd100,        1'b0);
    issue(skit_pkg::REQ_READ,   32'h0,          32'h0,          1'b0);
    issue(skit_pkg::REQ_READ,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1);
    issue(skit_pkg::REQ_DELETE, 32'h0,          32'h0,          1'b1);
    issue(skit_pkg::REQ_READ,   32'h0,          32'h0,          1'b1);
    issue(skit_pkg::REQ_DELETE, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1);
    issue(skit_pkg::REQ_ACCESS, 32'h5A5A_A5A5,  32'd1,          1'b0);
    issue(skit_pkg::REQ_DELETE, 32'h0,          32'h0,          1'b0);
    issue(skit_pkg::REQ_ACCESS, 32'hFFFF_FFFF,  32'd2,          1'b1);
    issue(skit_pkg::REQ_NONE,   $urandom,       $urandom,       1'b1);
    issue(skit_pkg::REQ_NONE,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1);
    issue(skit_pkg::REQ_READ,   32'h0,          32'h0,          1'b0);
    issue(skit_pkg::REQ_READ,   32'h0,          32'h0,          1'b1);
    drain();

    // random: a few recurring serials so hits and evictions both happen
    foreach (serial_pool[i]) serial_pool[i] = $urandom;
    clock_now = $urandom_range(0, 1000);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 700)
        drain();
      else if (n < 400 || n >= 550)
        while ($urandom_range(0, 99) < 26) idle_cycle();

      r = $urandom_range(0, 99);
      if (r < 60)      req = skit_pkg::REQ_ACCESS;
      else if (r < 75) req = skit_pkg::REQ_DELETE;
      else if (r < 95) req = skit_pkg::REQ_READ;
      else             req = skit_pkg::REQ_NONE;

      if ($urandom_range(0, 9) < 7) raw = serial_pool[$urandom_range(0, 3)];
      else                          raw = $urandom;
      if ($urandom_range(0, 7) == 0) serial_pool[$urandom_range(0, 3)] = $urandom;

      // mostly rising time with repeats, now and then a jump or the top value
      case ($urandom_range(0, 9))
        0:       clock_now = $urandom;
        1:       clock_now = 32'hFFFF_FFFF;
        2:       clock_now = clock_now;
        default: clock_now = clock_now + $urandom_range(1, 5);
      endcase

      issue(req, raw, clock_now, 1'($urandom));
    end

    // wind down and give the verdict
    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_words == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
